>>> rtl/hamming_sec_codec_core_assert.svh
// Assertion macros for the Hamming codec core
`ifndef HAMMING_SEC_CODEC_CORE_ASSERT_SVH
`define HAMMING_SEC_CODEC_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent, checked out of reset
`define HSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds at every edge out of reset
`define HSC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`else

`define HSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define HSC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/hsc_pkg.sv
`default_nettype none

package hsc_pkg;

    localparam int MAX_CODE_BITS = 64;
    localparam int SYND_BITS     = 7;
    localparam int LEN_BITS      = 7;
    localparam int MSG_BITS      = 6;

    // operation codes
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FIXED  = 2'd1;
    localparam logic [1:0] STATUS_UNCORR = 2'd2;

    // input word
    typedef struct packed {
        logic                     func;
        logic [MAX_CODE_BITS-1:0] data_in;
    } cmd_t;

    // result word
    typedef struct packed {
        logic [MAX_CODE_BITS-1:0] code_out;
        logic [SYND_BITS-1:0]     syndrome;
        logic [1:0]               status;
    } res_t;

    // stage 1 -> stage 2
    typedef struct packed {
        logic                     valid;
        logic                     func;
        logic [MAX_CODE_BITS-1:0] word;
    } s1_t;

    // stage 2 -> stage 3
    typedef struct packed {
        logic                     valid;
        logic                     func;
        logic [MAX_CODE_BITS-1:0] word;
        logic [SYND_BITS-1:0]     synd;
    } s2_t;

    function automatic logic is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // message bit that lands at codeword position p (p not a power of two)
    function automatic logic [MSG_BITS-1:0] msg_index(input int p);
        int cnt;
        cnt = 0;
        for (int q = 1; q < p; q++)
        begin
            if (!is_pow2(q))
            begin
                cnt = cnt + 1;
            end
        end
        return MSG_BITS'(cnt);
    endfunction

    // codeword length from the message length register
    // msg 0 counts as 1, lengths past 57 clamp to 57 (63-bit codeword)
    function automatic logic [LEN_BITS-1:0] code_len(input logic [MSG_BITS-1:0] msg);
        logic [LEN_BITS-1:0] m;
        logic [LEN_BITS-1:0] r;
        m = {1'b0, msg};
        if (m == '0)
        begin
            m = LEN_BITS'(1);
        end
        else if (m > LEN_BITS'(57))
        begin
            m = LEN_BITS'(57);
        end
        if (m <= LEN_BITS'(1))
        begin
            r = LEN_BITS'(2);
        end
        else if (m <= LEN_BITS'(4))
        begin
            r = LEN_BITS'(3);
        end
        else if (m <= LEN_BITS'(11))
        begin
            r = LEN_BITS'(4);
        end
        else if (m <= LEN_BITS'(26))
        begin
            r = LEN_BITS'(5);
        end
        else
        begin
            r = LEN_BITS'(6);
        end
        return m + r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hsc_expand.sv
`default_nettype none

// Stage 1: spread message bits over data positions, or take the codeword,
// and mask to the codeword length
module hsc_expand (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire hsc_pkg::cmd_t               cmd,
    input  wire logic [hsc_pkg::LEN_BITS-1:0] code_len,
    output hsc_pkg::s1_t                     s1
);

    logic [hsc_pkg::MAX_CODE_BITS-1:0] expd;
    logic [hsc_pkg::MAX_CODE_BITS-1:0] mask;
    logic [hsc_pkg::MAX_CODE_BITS-1:0] word_next;

    logic                              valid_reg;
    logic                              func_reg;
    logic [hsc_pkg::MAX_CODE_BITS-1:0] word_reg;

    // fixed wiring of message bits to non-power-of-two positions
    always_comb
    begin
        for (int b = 0; b < hsc_pkg::MAX_CODE_BITS; b++)
        begin
            if (hsc_pkg::is_pow2(b + 1))
            begin
                expd[b] = 1'b0;
            end
            else
            begin
                expd[b] = cmd.data_in[hsc_pkg::msg_index(b + 1)];
            end
            mask[b] = (hsc_pkg::LEN_BITS'(b) < code_len);
        end
        if (cmd.func == hsc_pkg::FUNC_DECODE)
        begin
            word_next = cmd.data_in & mask;
        end
        else
        begin
            word_next = expd & mask;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= cmd.func;
            word_reg <= word_next;
        end
    end

    assign s1 = '{valid: valid_reg, func: func_reg, word: word_reg};

endmodule

`default_nettype wire

>>> rtl/hsc_syndrome.sv
`default_nettype none

// Stage 2: parity check trees, bit i = XOR of positions with index bit i set
module hsc_syndrome (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire hsc_pkg::s1_t s1,
    output hsc_pkg::s2_t      s2
);

    logic [hsc_pkg::SYND_BITS-1:0]     synd_next;

    logic                              valid_reg;
    logic                              func_reg;
    logic [hsc_pkg::MAX_CODE_BITS-1:0] word_reg;
    logic [hsc_pkg::SYND_BITS-1:0]     synd_reg;

    // one XOR tree per syndrome bit
    always_comb
    begin
        synd_next = '0;
        for (int i = 0; i < hsc_pkg::SYND_BITS; i++)
        begin
            for (int b = 0; b < hsc_pkg::MAX_CODE_BITS; b++)
            begin
                if ((((b + 1) >> i) & 1) != 0)
                begin
                    synd_next[i] = synd_next[i] ^ s1.word[b];
                end
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= s1.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s1.valid)
        begin
            func_reg <= s1.func;
            word_reg <= s1.word;
            synd_reg <= synd_next;
        end
    end

    assign s2 = '{valid: valid_reg, func: func_reg, word: word_reg, synd: synd_reg};

endmodule

`default_nettype wire

>>> rtl/hsc_correct.sv
`default_nettype none

// Stage 3: insert parity bits (encode) or flip the named bit when it lies within the codeword (decode)
module hsc_correct (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire hsc_pkg::s2_t                 s2,
    input  wire logic [hsc_pkg::LEN_BITS-1:0] code_len,
    output logic                              done,
    output hsc_pkg::res_t                     result
);

    hsc_pkg::res_t res_next;
    logic          in_range;

    logic          done_reg;
    hsc_pkg::res_t result_reg;

    // build the result word
    always_comb
    begin
        res_next.code_out = s2.word;
        res_next.syndrome = '0;
        res_next.status   = hsc_pkg::STATUS_OK;
        in_range = (hsc_pkg::LEN_BITS'(s2.synd) <= code_len);
        if (s2.func == hsc_pkg::FUNC_ENCODE)
        begin
            // parity bit i sits at position 2^i
            for (int i = 0; i < hsc_pkg::SYND_BITS; i++)
            begin
                res_next.code_out[(1 << i) - 1] = s2.word[(1 << i) - 1] | s2.synd[i];
            end
        end
        else
        begin
            res_next.syndrome = s2.synd;
            if (s2.synd != '0)
            begin
                if (in_range)
                begin
                    for (int b = 0; b < hsc_pkg::MAX_CODE_BITS; b++)
                    begin
                        if (s2.synd == hsc_pkg::SYND_BITS'(b + 1))
                        begin
                            res_next.code_out[b] = ~s2.word[b];
                        end
                    end
                    res_next.status = hsc_pkg::STATUS_FIXED;
                end
                else
                begin
                    res_next.status = hsc_pkg::STATUS_UNCORR;
                end
            end
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2.valid;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s2.valid)
        begin
            result_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/hamming_sec_codec_core.sv
// Hamming SEC codec: an accepted start reaches the done strobe through the stage registers.
// Throughput one word per cycle: busy stays low, expand/check/correct stages
// each take a register stage and every stage carries its own valid bit.
// Reset (rst_n low, asynchronous) clears all valid bits and the done strobe and
// sets msg_len to 4 (7-bit codeword); the receiver cannot stall the results.
`default_nettype none

`include "hamming_sec_codec_core_assert.svh"

module hamming_sec_codec_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire hsc_pkg::cmd_t                cmd,
    input  wire logic                         cfg_we,
    input  wire logic [hsc_pkg::MSG_BITS-1:0] cfg_wdata,
    output logic                              done,
    output hsc_pkg::res_t                     result
);

    logic [hsc_pkg::LEN_BITS-1:0] code_len_reg;
    logic                         accept;
    hsc_pkg::s1_t                 s1;
    hsc_pkg::s2_t                 s2;

    // config register, held as the derived codeword length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_len_reg <= hsc_pkg::code_len(hsc_pkg::MSG_BITS'(4));
        end
        else if (cfg_we)
        begin
            code_len_reg <= hsc_pkg::code_len(cfg_wdata);
        end
    end

    // pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    hsc_expand u_expand (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .cmd      (cmd),
        .code_len (code_len_reg),
        .s1       (s1)
    );

    hsc_syndrome u_syndrome (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1),
        .s2    (s2)
    );

    hsc_correct u_correct (
        .clk      (clk),
        .rst_n    (rst_n),
        .s2       (s2),
        .code_len (code_len_reg),
        .done     (done),
        .result   (result)
    );

    // checks
    `HSC_ASSERT_IMPL(a_latency, clk, rst_n, accept, ##3 done, "result strobe missing")
    `HSC_ASSERT_IMPL(a_uncorr, clk, rst_n, done && (result.status == hsc_pkg::STATUS_UNCORR), (hsc_pkg::LEN_BITS'(result.syndrome) > code_len_reg), "uncorrectable within length")
    `HSC_ASSERT_IMPL(a_clean, clk, rst_n, done && (result.status == hsc_pkg::STATUS_OK), (result.syndrome == '0), "nonzero syndrome with ok status")
    `HSC_ASSERT_ALWAYS(a_len, clk, rst_n, (code_len_reg >= hsc_pkg::LEN_BITS'(3)) && (code_len_reg <= hsc_pkg::LEN_BITS'(63)), "codeword length out of range")

endmodule

`default_nettype wire
